// ===== rtl/multi_stack_shared_pool_core_defines.svh =====
// Assertion macros for the multi-stack shared pool core.
// Both macros sample on clk and are disabled while rst_n is low.
`ifndef MULTI_STACK_SHARED_POOL_CORE_DEFINES_SVH
`define MULTI_STACK_SHARED_POOL_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Consequent must hold in the same cycle as the antecedent.
`define MSP_AST_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define MSP_AST_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MSP_AST_SAME(label, ante, cons, msg)
`define MSP_AST_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== rtl/msp_pkg.sv =====
`default_nettype none

package msp_pkg;

  // Fixed field widths of the request and result channels
  localparam int REQ_W      = 2;
  localparam int SID_IN_W   = 2;
  localparam int VAL_W      = 32;
  localparam int ST_W       = 2;
  localparam int SLOT_OUT_W = 4;

  // Default sizing
  localparam int DEF_NUM_STACKS = 4;
  localparam int DEF_POOL_SLOTS = 16;
  localparam int DEF_DATA_WIDTH = 32;

  // Request codes; any other code acts as a peek
  localparam logic [REQ_W-1:0] REQ_PUSH = 2'd0;
  localparam logic [REQ_W-1:0] REQ_POP  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_PEEK = 2'd2;

  // Result status codes
  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [ST_W-1:0] ST_UNDERFLOW = 2'd2;

  // Value reported on push and on error
  localparam logic signed [VAL_W-1:0] NO_VALUE = -32'sd1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;  // latch request, read stack head
    logic look;    // read link and data memories
    logic commit;  // write back state, load result
  } msp_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/msp_ctrl.sv =====
`default_nettype none
`include "multi_stack_shared_pool_core_defines.svh"

module msp_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output msp_pkg::msp_cmd_t     cmd
);
  import msp_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_UPD
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   out_free;

  // Result register can take a new request when empty or being drained
  assign out_free = !out_valid_r || !out_stall;

  assign in_stall   = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign cmd.accept = (state_r == S_IDLE) && in_valid;
  assign cmd.look   = (state_r == S_LOOK);
  assign cmd.commit = (state_r == S_UPD) && out_free;

  // Sequence one request: head read, memory read, write back
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (out_free) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `MSP_AST_NEXT(a_accept_to_look, cmd.accept, cmd.look, "accept not followed by look")
  `MSP_AST_NEXT(a_commit_shows, cmd.commit, out_valid, "commit did not raise out_valid")
  `MSP_AST_NEXT(a_commit_frees, cmd.commit, !in_stall, "commit did not return to idle")

endmodule

`default_nettype wire

// ===== rtl/msp_dp.sv =====
`default_nettype none
`include "multi_stack_shared_pool_core_defines.svh"

module msp_dp #(
  parameter int NUM_STACKS = msp_pkg::DEF_NUM_STACKS,
  parameter int POOL_SLOTS = msp_pkg::DEF_POOL_SLOTS,
  parameter int DATA_WIDTH = msp_pkg::DEF_DATA_WIDTH
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire msp_pkg::msp_cmd_t                     cmd,
  input  wire logic [msp_pkg::REQ_W-1:0]             in_req_type,
  input  wire logic [msp_pkg::SID_IN_W-1:0]          in_stack_id,
  input  wire logic signed [msp_pkg::VAL_W-1:0]      in_push_value,
  output logic [msp_pkg::ST_W-1:0]                   out_status,
  output logic signed [msp_pkg::VAL_W-1:0]           out_value,
  output logic [msp_pkg::SLOT_OUT_W-1:0]             out_slot_index
);
  import msp_pkg::*;

  localparam int PTR_W = $clog2(POOL_SLOTS);
  localparam int SID_W = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int WM_W  = $clog2(POOL_SLOTS + 1);

  typedef struct packed {
    logic             nul;
    logic [PTR_W-1:0] idx;
  } ptr_t;

  // Storage
  ptr_t                  hd_mem [NUM_STACKS];
  logic [NUM_STACKS-1:0] hv_r;
  ptr_t                  lk_mem [POOL_SLOTS];
  logic [DATA_WIDTH-1:0] dt_mem [POOL_SLOTS];
  ptr_t                  fr_r;
  logic [WM_W-1:0]       wm_r;

  // Request registers
  logic [REQ_W-1:0]      req_r;
  logic [SID_W-1:0]      sid_r;
  logic [DATA_WIDTH-1:0] val_r;
  ptr_t                  hd_r;
  logic                  hv_rd_r;

  // Memory read registers
  ptr_t                  lk_rd_r;
  logic signed [DATA_WIDTH-1:0] dt_rd_r;
  logic [PTR_W-1:0]      laddr_r;
  logic                  fresh_r;

  // Result registers
  logic [ST_W-1:0]         status_r;
  logic signed [VAL_W-1:0] value_r;
  logic [SLOT_OUT_W-1:0]   slot_r;

  logic [SID_IN_W-1:0] sid_red;
  logic [SID_W-1:0]    sid_mod;
  logic                is_push;
  logic                is_pop;
  logic                hd_null;
  logic                push_ok;
  logic                pop_ok;
  logic                read_ok;
  logic [PTR_W-1:0]    lk_addr;
  ptr_t                rst_link;
  ptr_t                link_eff;
  ptr_t                hd_eff;
  ptr_t                lk_wdata;
  ptr_t                hd_wdata;

  // Fold the stack number into range
  always_comb begin
    sid_red = in_stack_id;
    for (int k = 0; k < 3; k++) begin
      if (32'(sid_red) >= NUM_STACKS) begin
        sid_red = sid_red - SID_IN_W'(NUM_STACKS);
      end
    end
    sid_mod = SID_W'(sid_red);
  end

  // Decode the request against the state read so far
  assign is_push = (req_r == REQ_PUSH);
  assign is_pop  = (req_r == REQ_POP);
  assign hd_null = !hv_rd_r || hd_r.nul;
  assign push_ok = is_push && !fr_r.nul;
  assign pop_ok  = is_pop && !hd_null;
  assign read_ok = !is_push && !hd_null;
  assign lk_addr = is_push ? fr_r.idx : hd_r.idx;

  // Slots at or above the watermark still hold their reset link
  assign rst_link.idx = laddr_r + 1'b1;
  assign rst_link.nul = (laddr_r == PTR_W'(POOL_SLOTS - 1));
  assign link_eff     = fresh_r ? rst_link : lk_rd_r;
  assign hd_eff.nul   = hd_null;
  assign hd_eff.idx   = hd_r.idx;

  // Push links the slot onto the stack; pop returns it to the free list
  assign lk_wdata     = is_push ? hd_eff : fr_r;
  assign hd_wdata.nul = is_push ? 1'b0 : link_eff.nul;
  assign hd_wdata.idx = is_push ? fr_r.idx : link_eff.idx;

  // Latch request and read the stack head
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_r   <= in_req_type;
      sid_r   <= sid_mod;
      val_r   <= DATA_WIDTH'(in_push_value);
      hd_r    <= hd_mem[sid_mod];
      hv_rd_r <= hv_r[sid_mod];
    end
    if (cmd.commit && (push_ok || pop_ok)) begin
      hd_mem[sid_r] <= hd_wdata;
    end
  end

  // Stack head valid bits: an unwritten head reads as empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hv_r <= '0;
    end else if (cmd.commit && (push_ok || pop_ok)) begin
      hv_r[sid_r] <= 1'b1;
    end
  end

  // Link memory
  always_ff @(posedge clk) begin
    if (cmd.look) begin
      lk_rd_r <= lk_mem[lk_addr];
      laddr_r <= lk_addr;
      fresh_r <= (WM_W'(lk_addr) >= wm_r);
    end
    if (cmd.commit && (push_ok || pop_ok)) begin
      lk_mem[laddr_r] <= lk_wdata;
    end
  end

  // Data memory
  always_ff @(posedge clk) begin
    if (cmd.look) begin
      dt_rd_r <= dt_mem[hd_r.idx];
    end
    if (cmd.commit && push_ok) begin
      dt_mem[fr_r.idx] <= val_r;
    end
  end

  // Free list head and fresh-slot watermark
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_r <= '0;
      wm_r <= '0;
    end else if (cmd.commit) begin
      if (push_ok) begin
        fr_r <= link_eff;
        if (fresh_r) begin
          wm_r <= wm_r + 1'b1;
        end
      end else if (pop_ok) begin
        fr_r.nul <= 1'b0;
        fr_r.idx <= laddr_r;
      end
    end
  end

  // Load the result
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      priority if (push_ok) begin
        status_r <= ST_OK;
        value_r  <= NO_VALUE;
        slot_r   <= SLOT_OUT_W'(fr_r.idx);
      end else if (is_push) begin
        status_r <= ST_OVERFLOW;
        value_r  <= NO_VALUE;
        slot_r   <= '0;
      end else if (read_ok) begin
        status_r <= ST_OK;
        value_r  <= VAL_W'(dt_rd_r);
        slot_r   <= SLOT_OUT_W'(hd_r.idx);
      end else begin
        status_r <= ST_UNDERFLOW;
        value_r  <= NO_VALUE;
        slot_r   <= '0;
      end
    end
  end

  assign out_status     = status_r;
  assign out_value      = value_r;
  assign out_slot_index = slot_r;

  `MSP_AST_NEXT(a_wm_step, cmd.commit && push_ok && fresh_r, wm_r == WM_W'($past(wm_r) + 1'b1), "watermark did not advance")
  `MSP_AST_NEXT(a_pop_frees, cmd.commit && pop_ok, !fr_r.nul && fr_r.idx == $past(laddr_r), "popped slot not on free list")
  `MSP_AST_SAME(a_read_written, cmd.commit && read_ok, !fresh_r, "stack top points at unwritten slot")

endmodule

`default_nettype wire

// ===== rtl/multi_stack_shared_pool_core.sv =====
// Several LIFO stacks sharing one pool of slots, with a free list.
// Request channel: in_valid / in_stall with in_req_type (push, pop, peek;
// code 3 acts as a peek), in_stack_id (taken modulo NUM_STACKS) and
// in_push_value. Result channel: out_valid / out_stall with out_status,
// out_value and out_slot_index; exactly one result per request.
// A request passes these steps in order: read the stack head, read the
// link and data memories at that head or at the free head, and write
// back links, heads and the result register. The next request is taken
// in the cycle after write back.
// Reset: all stacks empty, every slot free in ascending order. No clearing
// pass runs; a watermark marks which slots still hold their reset link, so
// the block takes requests in the first cycle after reset.
// When the receiver stalls, the result is held; one more request is taken
// and waits in its write-back step until the result register frees.
`default_nettype none

module multi_stack_shared_pool_core #(
  parameter int NUM_STACKS = msp_pkg::DEF_NUM_STACKS,
  parameter int POOL_SLOTS = msp_pkg::DEF_POOL_SLOTS,
  parameter int DATA_WIDTH = msp_pkg::DEF_DATA_WIDTH
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [msp_pkg::REQ_W-1:0]         in_req_type,
  input  wire logic [msp_pkg::SID_IN_W-1:0]      in_stack_id,
  input  wire logic signed [msp_pkg::VAL_W-1:0]  in_push_value,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [msp_pkg::ST_W-1:0]               out_status,
  output logic signed [msp_pkg::VAL_W-1:0]       out_value,
  output logic [msp_pkg::SLOT_OUT_W-1:0]         out_slot_index
);
  import msp_pkg::*;

  msp_cmd_t cmd;

  // Sequencer
  msp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Pool memories, heads and result register
  msp_dp #(
    .NUM_STACKS (NUM_STACKS),
    .POOL_SLOTS (POOL_SLOTS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_req_type    (in_req_type),
    .in_stack_id    (in_stack_id),
    .in_push_value  (in_push_value),
    .out_status     (out_status),
    .out_value      (out_value),
    .out_slot_index (out_slot_index)
  );

endmodule

`default_nettype wire

// ===== tb/sv/tb_multi_stack_shared_pool_core.sv =====
`timescale 1ns / 100ps

module tb_multi_stack_shared_pool_core;
  import msp_pkg::*;

  localparam int CLK_PERIOD = 20;
  localparam int NSTACK = DEF_NUM_STACKS;
  localparam int NSLOT = DEF_POOL_SLOTS;
  localparam int SLOT_W = $clog2(NSLOT);
  // Unused request code, behaves as a peek
  localparam logic [REQ_W-1:0] REQ_PEEK_ALT = 2'd3;
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_LOGGED = 40;
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    logic              nul;
    logic [SLOT_W-1:0] idx;
  } slot_ptr_t;

  typedef struct packed {
    logic [ST_W-1:0]          status;
    logic signed [VAL_W-1:0]  value;
    logic [SLOT_OUT_W-1:0]    slot;
  } pool_result_t;

  // Tracks the pool state and the results still owed by the block
  class stack_pool_scoreboard;
    logic signed [VAL_W-1:0] slot_val [NSLOT];
    slot_ptr_t next_slot [NSLOT];
    slot_ptr_t stack_top [NSTACK];
    slot_ptr_t free_top;
    pool_result_t due_results[$];
    int errors;

    function new();
      for (int i = 0; i < NSLOT; i++) begin
        slot_val[i] = '0;
        next_slot[i].nul = (i == NSLOT - 1);
        next_slot[i].idx = (i == NSLOT - 1) ? '0 : SLOT_W'(i + 1);
      end
      for (int i = 0; i < NSTACK; i++) begin
        stack_top[i].nul = 1'b1;
        stack_top[i].idx = '0;
      end
      free_top.nul = 1'b0;
      free_top.idx = '0;
      errors = 0;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    // Apply one accepted request to the pool and queue its result
    function void note_request(logic [REQ_W-1:0] kind, logic [SID_IN_W-1:0] sid,
                               logic signed [VAL_W-1:0] push_value);
      pool_result_t res;
      slot_ptr_t top;
      int unsigned which;
      which = sid % NSTACK;
      top = stack_top[which];
      res.status = ST_OK;
      res.value = NO_VALUE;
      res.slot = '0;
      if (kind == REQ_PUSH) begin
        if (free_top.nul) begin
          res.status = ST_OVERFLOW;
        end else begin
          // take the free head and link it on top of the stack
          res.slot = free_top.idx;
          slot_val[free_top.idx] = push_value;
          stack_top[which] = free_top;
          free_top = next_slot[res.slot];
          next_slot[res.slot] = top;
        end
      end else if (top.nul) begin
        res.status = ST_UNDERFLOW;
      end else begin
        res.value = slot_val[top.idx];
        res.slot = top.idx;
        if (kind == REQ_POP) begin
          // unlink the top slot and return it to the free list
          stack_top[which] = next_slot[top.idx];
          next_slot[top.idx] = free_top;
          free_top = top;
        end
      end
      due_results.push_back(res);
    endfunction

    task report_mismatch(string what);
      errors++;
      if (errors <= MAX_LOGGED) $display("%0t mismatch: %s", $time, what);
    endtask

    // Compare one accepted result with the oldest expectation
    task check_result(logic [ST_W-1:0] status, logic signed [VAL_W-1:0] value,
                      logic [SLOT_OUT_W-1:0] slot);
      pool_result_t want;
      if (due_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result status %0d value %0d slot %0d",
                                  status, value, slot));
        return;
      end
      want = due_results.pop_front();
      if (status !== want.status)
        report_mismatch($sformatf("status %0d, want %0d", status, want.status));
      if (value !== want.value)
        report_mismatch($sformatf("value %0d, want %0d", value, want.value));
      if (slot !== want.slot)
        report_mismatch($sformatf("slot %0d, want %0d", slot, want.slot));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [REQ_W-1:0] in_req_type = REQ_PUSH;
  logic [SID_IN_W-1:0] in_stack_id = '0;
  logic signed [VAL_W-1:0] in_push_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [ST_W-1:0] out_status;
  logic signed [VAL_W-1:0] out_value;
  logic [SLOT_OUT_W-1:0] out_slot_index;

  int unsigned send_idle_pct = 23;
  int unsigned recv_stall_pct = 50;
  int unsigned hold_req = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;

  logic signed [VAL_W-1:0] edge_vals [4] = '{32'h7fffffff, 32'h80000000, 32'h00000000,
                                             32'hffffffff};

  stack_pool_scoreboard sb = new();

  always #(CLK_PERIOD / 2) clk = ~clk;

  multi_stack_shared_pool_core uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_stack_id    (in_stack_id),
    .in_push_value  (in_push_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_value      (out_value),
    .out_slot_index (out_slot_index)
  );

  // Sample both channels at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        sb.check_result(out_status, out_value, out_slot_index);
      if (in_valid && !in_stall)
        sb.note_request(in_req_type, in_stack_id, in_push_value);
    end
  end

  // Abort when neither channel moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off when requested
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Offer one request, idling first at random; return once it is taken
  task automatic send_request(logic [REQ_W-1:0] kind, logic [SID_IN_W-1:0] sid,
                              logic signed [VAL_W-1:0] push_value);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_req_type <= kind;
    in_stack_id <= sid;
    in_push_value <= push_value;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(7))
      0, 1, 2: return edge_vals[$urandom_range(3)];
      3: return VAL_W'($urandom_range(15));
      default: return $urandom();
    endcase
  endfunction

  // Random traffic in bursts that lean toward filling the pool, draining it, or neither
  task automatic send_random(int unsigned count);
    int unsigned push_pct;
    int unsigned roll;
    logic [REQ_W-1:0] kind;
    push_pct = 50;
    for (int n = 0; n < count; n++) begin
      if (n % 24 == 0) begin
        case ($urandom_range(2))
          0: push_pct = 15;
          1: push_pct = 50;
          default: push_pct = 85;
        endcase
      end
      roll = $urandom_range(99);
      if (roll < push_pct) begin
        kind = REQ_PUSH;
      end else begin
        roll = $urandom_range(9);
        kind = (roll < 6) ? REQ_POP : (roll < 9) ? REQ_PEEK : REQ_PEEK_ALT;
      end
      send_request(kind, SID_IN_W'($urandom_range(NSTACK - 1)), pick_value());
    end
  endtask

  // Drop the request and wait until every owed result has come back
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty stacks, fill the pool, overflow, then reuse a freed slot
    send_request(REQ_PEEK, 2'd0, pick_value());
    send_request(REQ_POP, 2'd3, pick_value());
    send_request(REQ_PEEK_ALT, 2'd2, pick_value());
    for (int i = 0; i < NSLOT; i++)
      send_request(REQ_PUSH, SID_IN_W'(i % NSTACK), (i < 4) ? edge_vals[i] : pick_value());
    send_request(REQ_PUSH, 2'd1, pick_value());
    send_request(REQ_PEEK, 2'd0, pick_value());
    send_request(REQ_PEEK_ALT, 2'd1, pick_value());
    send_request(REQ_POP, 2'd2, pick_value());
    send_request(REQ_POP, 2'd3, pick_value());
    send_request(REQ_PUSH, 2'd2, pick_value());

    // Sender idles less than the receiver; hold the receiver off midway
    send_random(150);
    hold_req = HOLD_CYCLES;
    send_random(460);
    drain_results();

    // Receiver idles less than the sender; pause the sender until drained
    send_idle_pct = 50;
    recv_stall_pct = 23;
    send_random(300);
    drain_results();
    send_random(310);
    drain_results();

    // No idling on either side
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_random(610);
    @(negedge clk);
    in_valid <= 1'b0;
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
